/* rtl/lpht_pkg.sv */
// ---------------------------------------------------------------------------
// lpht_pkg - shared types and constants of the linear probe hash table
// Table geometry, command and status codes, and the structs that travel
// between the front end, the job queue and the probe engine.
// ---------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam bit HOME_POW2   = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int KV_BITS     = KEY_BITS + VALUE_BITS;
  localparam int NIB_BITS    = 4;
  localparam int KEY_NIBBLES = KEY_BITS / NIB_BITS;
  localparam int STEP_BITS   = $clog2(KEY_NIBBLES + 1);
  localparam int OUT_SLOT_BITS = 6;

  typedef logic [SLOT_BITS-1:0] slot_t;

  localparam slot_t LAST_SLOT = slot_t'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_FIND       = 2'd1,
    CMD_ERASE      = 2'd2,
    CMD_LOOKUP_ADD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_NOTFOUND = 2'd1,
    RES_DUP      = 2'd2,
    RES_FULL     = 2'd3
  } status_t;

  // Slot state as stored in the status memory
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  typedef enum logic [2:0] {
    ENG_CLEAR,
    ENG_IDLE,
    ENG_PROBE,
    ENG_MOVE,
    ENG_REPLY
  } eng_state_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    slot_t                 home;
  } job_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] value;
    slot_t                 slot;
  } result_t;

endpackage

/* rtl/lpht_front.sv */
// ---------------------------------------------------------------------------
// lpht_front - command intake and home slot computation
// Takes one transaction at a time, works out the key's home slot and
// pushes the finished job into the queue.
// ---------------------------------------------------------------------------
module lpht_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               enable,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  lpht_pkg::cmd_t                     in_cmd,
  input  logic [lpht_pkg::KEY_BITS-1:0]      in_key,
  input  logic [lpht_pkg::VALUE_BITS-1:0]    in_value,
  output logic                               push_valid,
  output lpht_pkg::job_t                     push_job,
  input  logic                               push_ready
);

  logic                                 hold_valid_r, hold_valid_nxt;
  lpht_pkg::job_t                       job_r, job_nxt;
  logic [lpht_pkg::KEY_BITS-1:0]        key_sh_r, key_sh_nxt;
  logic [lpht_pkg::STEP_BITS-1:0]       steps_r, steps_nxt;
  logic                                 done;
  logic                                 push;
  logic                                 take;

  // Four restoring reduction steps: fold one nibble of the key into the remainder
  function automatic lpht_pkg::slot_t mod_step4(input lpht_pkg::slot_t rem,
                                                input logic [lpht_pkg::NIB_BITS-1:0] nib);
    logic [lpht_pkg::SLOT_BITS:0] t;
    lpht_pkg::slot_t              r;
    r = rem;
    for (int i = lpht_pkg::NIB_BITS - 1; i >= 0; i--) begin
      t = {r, nib[i]};
      if (t >= (lpht_pkg::SLOT_BITS + 1)'(lpht_pkg::TABLE_SLOTS)) begin
        t = t - (lpht_pkg::SLOT_BITS + 1)'(lpht_pkg::TABLE_SLOTS);
      end
      r = t[lpht_pkg::SLOT_BITS-1:0];
    end
    return r;
  endfunction

  assign done       = hold_valid_r && (steps_r == '0);
  assign push       = done && push_ready;
  assign in_tready  = enable && (!hold_valid_r || push);
  assign take       = in_tvalid && in_tready;
  assign push_valid = done;
  assign push_job   = job_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    job_nxt        = job_r;
    key_sh_nxt     = key_sh_r;
    steps_nxt      = steps_r;
    if (push) begin
      hold_valid_nxt = 1'b0;
    end
    if (take) begin
      hold_valid_nxt = 1'b1;
      job_nxt.cmd    = in_cmd;
      job_nxt.key    = in_key;
      job_nxt.value  = in_value;
      key_sh_nxt     = in_key;
      if (lpht_pkg::HOME_POW2) begin
        job_nxt.home = in_key[lpht_pkg::SLOT_BITS-1:0];
        steps_nxt    = '0;
      end else begin
        job_nxt.home = '0;
        steps_nxt    = lpht_pkg::STEP_BITS'(lpht_pkg::KEY_NIBBLES);
      end
    end else if (hold_valid_r && (steps_r != '0)) begin
      // advance the reduction by one nibble, most significant first
      job_nxt.home = mod_step4(job_r.home,
                               key_sh_r[lpht_pkg::KEY_BITS-1 -: lpht_pkg::NIB_BITS]);
      key_sh_nxt   = key_sh_r << lpht_pkg::NIB_BITS;
      steps_nxt    = steps_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    job_r    <= job_nxt;
    key_sh_r <= key_sh_nxt;
    steps_r  <= steps_nxt;
  end

endmodule

/* rtl/lpht_queue.sv */
// ---------------------------------------------------------------------------
// lpht_queue - two-entry job queue
// Decouples the front end from the probe engine.
// ---------------------------------------------------------------------------
module lpht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  lpht_pkg::job_t push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output lpht_pkg::job_t pop_job,
  input  logic           pop
);

  lpht_pkg::job_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/lpht_back.sv */
// ---------------------------------------------------------------------------
// lpht_back - probe engine and slot memories
// Runs one job at a time: probes one slot per cycle, then writes the
// table where needed and hands the result to the output stage.
// ---------------------------------------------------------------------------
module lpht_back (
  input  logic              clk,
  input  logic              rst_n,
  output logic              clearing,
  input  logic              job_valid,
  input  lpht_pkg::job_t    job_in,
  output logic              job_pop,
  output logic              res_valid,
  output lpht_pkg::result_t res,
  input  logic              res_ready
);

  // Slot memories: status, and key with value side by side
  logic [1:0]                   st_mem [lpht_pkg::TABLE_SLOTS];
  logic [lpht_pkg::KV_BITS-1:0] kv_mem [lpht_pkg::TABLE_SLOTS];
  logic [1:0]                   rd_st_r;
  logic [lpht_pkg::KV_BITS-1:0] rd_kv_r;

  lpht_pkg::slot_t              rd_addr;
  logic                         st_we;
  lpht_pkg::slot_t              st_waddr;
  logic [1:0]                   st_wdata;
  logic                         kv_we;
  lpht_pkg::slot_t              kv_waddr;
  logic [lpht_pkg::KV_BITS-1:0] kv_wdata;

  lpht_pkg::eng_state_t state_r, state_nxt;
  lpht_pkg::slot_t      clr_idx_r, clr_idx_nxt;
  lpht_pkg::job_t       job_r, job_nxt;
  lpht_pkg::slot_t      pidx_r, pidx_nxt;
  lpht_pkg::slot_t      n_r, n_nxt;
  logic                 have_tomb_r, have_tomb_nxt;
  lpht_pkg::slot_t      tomb_r, tomb_nxt;
  lpht_pkg::result_t    res_r, res_nxt;

  logic                 live, empty, key_eq, hit, last;
  logic                 first_tomb, have_now;
  lpht_pkg::slot_t      tomb_now;
  lpht_pkg::slot_t      pidx_next;
  logic [lpht_pkg::VALUE_BITS-1:0] rd_value;

  assign live       = (rd_st_r == lpht_pkg::ST_LIVE);
  assign empty      = (rd_st_r == lpht_pkg::ST_EMPTY);
  assign key_eq     = (rd_kv_r[lpht_pkg::KEY_BITS-1:0] == job_r.key);
  assign hit        = live && key_eq;
  assign last       = (n_r == lpht_pkg::LAST_SLOT);
  assign first_tomb = !live && !empty && !have_tomb_r;
  assign have_now   = have_tomb_r || first_tomb;
  assign tomb_now   = have_tomb_r ? tomb_r : pidx_r;
  assign pidx_next  = (pidx_r == lpht_pkg::LAST_SLOT) ? '0 : pidx_r + 1'b1;
  assign rd_value   = rd_kv_r[lpht_pkg::KV_BITS-1:lpht_pkg::KEY_BITS];

  assign clearing  = (state_r == lpht_pkg::ENG_CLEAR);
  assign res_valid = (state_r == lpht_pkg::ENG_REPLY);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    job_nxt       = job_r;
    pidx_nxt      = pidx_r;
    n_nxt         = n_r;
    have_tomb_nxt = have_tomb_r;
    tomb_nxt      = tomb_r;
    res_nxt       = res_r;
    job_pop       = 1'b0;
    rd_addr       = pidx_r;
    st_we         = 1'b0;
    st_waddr      = pidx_r;
    st_wdata      = lpht_pkg::ST_TOMB;
    kv_we         = 1'b0;
    kv_waddr      = pidx_r;
    kv_wdata      = {job_r.value, job_r.key};

    case (state_r)
      lpht_pkg::ENG_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx_r;
        st_wdata = lpht_pkg::ST_EMPTY;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == lpht_pkg::LAST_SLOT) begin
          clr_idx_nxt = '0;
          state_nxt   = lpht_pkg::ENG_IDLE;
        end
      end

      lpht_pkg::ENG_IDLE: begin
        rd_addr = job_in.home;
        if (job_valid) begin
          job_pop       = 1'b1;
          job_nxt       = job_in;
          pidx_nxt      = job_in.home;
          n_nxt         = '0;
          have_tomb_nxt = 1'b0;
          state_nxt     = lpht_pkg::ENG_PROBE;
        end
      end

      lpht_pkg::ENG_PROBE: begin
        // read the following slot ahead; dropped if this probe ends the job
        rd_addr  = pidx_next;
        pidx_nxt = pidx_next;
        n_nxt    = n_r + 1'b1;
        res_nxt  = '{status: lpht_pkg::RES_OK, value: '0, slot: '0};
        if (job_r.cmd == lpht_pkg::CMD_INSERT) begin
          if (hit) begin
            res_nxt.status = lpht_pkg::RES_DUP;
            state_nxt      = lpht_pkg::ENG_REPLY;
          end else if (!live) begin
            st_we    = 1'b1;
            st_wdata = lpht_pkg::ST_LIVE;
            kv_we    = 1'b1;
            res_nxt  = '{status: lpht_pkg::RES_OK, value: job_r.value, slot: pidx_r};
            state_nxt = lpht_pkg::ENG_REPLY;
          end else if (last) begin
            res_nxt.status = lpht_pkg::RES_FULL;
            state_nxt      = lpht_pkg::ENG_REPLY;
          end
        end else if (hit) begin
          state_nxt = lpht_pkg::ENG_REPLY;
          if (job_r.cmd == lpht_pkg::CMD_ERASE) begin
            // a move followed by erase leaves both slots tombstones
            st_we   = 1'b1;
            res_nxt = '{status: lpht_pkg::RES_OK, value: rd_value, slot: tomb_now};
          end else if (have_tomb_r) begin
            // move the entry into the first tombstone passed
            st_we    = 1'b1;
            st_waddr = tomb_r;
            st_wdata = lpht_pkg::ST_LIVE;
            kv_we    = 1'b1;
            kv_waddr = tomb_r;
            kv_wdata = rd_kv_r;
            pidx_nxt = pidx_r;
            res_nxt  = '{status: lpht_pkg::RES_OK, value: rd_value, slot: tomb_r};
            state_nxt = lpht_pkg::ENG_MOVE;
          end else begin
            res_nxt = '{status: lpht_pkg::RES_OK, value: rd_value, slot: pidx_r};
          end
        end else if (empty || last) begin
          state_nxt = lpht_pkg::ENG_REPLY;
          if (job_r.cmd == lpht_pkg::CMD_LOOKUP_ADD) begin
            if (have_now || empty) begin
              // add the key with value zero at the first free slot
              st_we    = 1'b1;
              st_waddr = tomb_now;
              st_wdata = lpht_pkg::ST_LIVE;
              kv_we    = 1'b1;
              kv_waddr = tomb_now;
              kv_wdata = {{lpht_pkg::VALUE_BITS{1'b0}}, job_r.key};
              res_nxt  = '{status: lpht_pkg::RES_OK, value: '0, slot: tomb_now};
            end else begin
              res_nxt.status = lpht_pkg::RES_FULL;
            end
          end else begin
            res_nxt.status = lpht_pkg::RES_NOTFOUND;
          end
        end else if (first_tomb) begin
          have_tomb_nxt = 1'b1;
          tomb_nxt      = pidx_r;
        end
      end

      lpht_pkg::ENG_MOVE: begin
        // retire the old slot of the moved entry
        st_we     = 1'b1;
        state_nxt = lpht_pkg::ENG_REPLY;
      end

      lpht_pkg::ENG_REPLY: begin
        if (res_ready) begin
          state_nxt = lpht_pkg::ENG_IDLE;
        end
      end

      default: begin
        state_nxt = lpht_pkg::ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpht_pkg::ENG_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
    job_r       <= job_nxt;
    pidx_r      <= pidx_nxt;
    n_r         <= n_nxt;
    have_tomb_r <= have_tomb_nxt;
    tomb_r      <= tomb_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    rd_st_r <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      kv_mem[kv_waddr] <= kv_wdata;
    end
    rd_kv_r <= kv_mem[rd_addr];
  end

endmodule

/* rtl/linear_probe_hash_table.sv */
// ---------------------------------------------------------------------------
// linear_probe_hash_table - open-addressing hash table with linear probing
// Insert, find, erase and lookup-or-add on 32-bit keys with 32-bit values,
// lazy deletion through tombstones, one result per command.
// ---------------------------------------------------------------------------
// After reset the block sweeps all TABLE_SLOTS slots (64 by default) of
// the status memory and holds in_tready low meanwhile. The probe engine
// then runs one command at a time, probing one slot per cycle from the
// key's home slot until a hit, a free slot for an insert, an empty slot
// for the other commands, or a full wrap; a find or lookup that hits an
// entry past a tombstone moves it into the first tombstone passed, in an
// extra move state. The home slot is the key modulo TABLE_SLOTS: its low
// bits when the slot count is a power of two, otherwise a nibble-serial
// reduction in the front end that overlaps with the engine's work. A
// two-entry queue between the front end and the engine, and a registered
// output stage, let both sides stall independently.
// ---------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found_value[31:0], slot_index[37:32], zero[39:38]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic              clearing;
  logic              push_valid;
  logic              push_ready;
  lpht_pkg::job_t    push_job;
  logic              job_valid;
  lpht_pkg::job_t    job_head;
  logic              job_pop;
  logic              res_valid;
  logic              res_ready;
  lpht_pkg::result_t res;

  // Output register
  logic                                 out_valid_r, out_valid_nxt;
  lpht_pkg::status_t                    out_status_r;
  logic [lpht_pkg::VALUE_BITS-1:0]      out_value_r;
  logic [lpht_pkg::OUT_SLOT_BITS-1:0]   out_slot_r;

  // Intake: capture the command and compute the home slot
  lpht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (!clearing),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (lpht_pkg::cmd_t'(in_tuser)),
    .in_key     (in_tdata[31:0]),
    .in_value   (in_tdata[63:32]),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // Hold finished jobs until the engine is free
  lpht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (job_valid),
    .pop_job    (job_head),
    .pop        (job_pop)
  );

  // Probe the table and apply the command
  lpht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .job_valid (job_valid),
    .job_in    (job_head),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Take a new result whenever the output register is empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
      out_slot_r   <= lpht_pkg::OUT_SLOT_BITS'(res.slot);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

/* test/linear_probe_hash_table_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// linear_probe_hash_table_test - self-checking bench for the probe hash table
// Drives insert, find, erase and lookup-or-add commands through the input
// stream, mirrors the slot array in a local model to predict every reply,
// and compares each reply field by field in order of arrival. A directed
// table opens the run; random phases then work the table through clustered
// keys, a fill to full, a mass erase and a tombstone-heavy steady state.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_test;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 12;
  localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles
  localparam int DRAIN_WAIT  = 40;       // settle time after the last reply
  localparam int TIMEOUT_NS  = 8000000;  // overall run time limit, in ns
  localparam int SLOTS       = lpht_pkg::TABLE_SLOTS;
  localparam int KB          = lpht_pkg::KEY_BITS;
  localparam int VB          = lpht_pkg::VALUE_BITS;
  localparam int HI_BITS     = lpht_pkg::KEY_BITS - lpht_pkg::SLOT_BITS;

  // One reply as the block reports it
  typedef struct packed {
    lpht_pkg::status_t                  status;
    logic [VB-1:0]                      value;
    logic [lpht_pkg::OUT_SLOT_BITS-1:0] slot;
  } reply_t;

  // One row of the directed opening: the reply is typed in only where
  // it is obvious, every other row is left to the mirror
  typedef struct {
    lpht_pkg::cmd_t cmd;
    logic [KB-1:0]  key;
    logic [VB-1:0]  value;
    bit             typed;
    reply_t         want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // key[31:0], value[63:32]
  logic [1:0]  in_tuser;    // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // found_value[31:0], slot_index[37:32], zero[39:38]
  logic [1:0]  out_tuser;   // status[1:0]

  linear_probe_hash_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Mirror of the slot array, kept in step with accepted commands
  logic [1:0]    mirror_st  [SLOTS];
  logic [KB-1:0] mirror_key [SLOTS];
  logic [VB-1:0] mirror_val [SLOTS];

  reply_t   reply_q[$];     // replies still owed by the block, oldest first
  dir_row_t dir_tab[$];
  int       errors;
  bit       tx_idle_en;
  bit       rx_idle_en;
  bit       hold_req;       // ask the receiver for one long hold-off
  int       cluster_base;
  logic [HI_BITS-1:0] key_hi [4];

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // -------------------------------------------------------------------------
  // Mirror of the probe logic
  // -------------------------------------------------------------------------

  // Walk from the home slot to a hit, an empty slot or a full wrap. On a hit
  // past a tombstone, pull the entry back into the first tombstone passed.
  function automatic bit locate_entry(input logic [KB-1:0] key, output int where);
    int idx;
    int tomb;
    bit have_tomb;
    idx = int'(key % SLOTS);
    tomb = 0;
    have_tomb = 1'b0;
    where = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (mirror_st[idx] == lpht_pkg::ST_EMPTY) return 1'b0;
      if (mirror_st[idx] == lpht_pkg::ST_LIVE && mirror_key[idx] == key) begin
        if (have_tomb) begin
          mirror_key[tomb] = mirror_key[idx];
          mirror_val[tomb] = mirror_val[idx];
          mirror_st[tomb]  = lpht_pkg::ST_LIVE;
          mirror_st[idx]   = lpht_pkg::ST_TOMB;
          idx = tomb;
        end
        where = idx;
        return 1'b1;
      end
      if (mirror_st[idx] != lpht_pkg::ST_LIVE && !have_tomb) begin
        have_tomb = 1'b1;
        tomb = idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    return 1'b0;
  endfunction

  // Claim the first empty or tombstone slot; stop early on a live duplicate
  function automatic lpht_pkg::status_t place_entry(input logic [KB-1:0] key,
                                                    input logic [VB-1:0] value,
                                                    output int where);
    int idx;
    idx = int'(key % SLOTS);
    where = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (mirror_st[idx] == lpht_pkg::ST_LIVE) begin
        if (mirror_key[idx] == key) return lpht_pkg::RES_DUP;
      end else begin
        mirror_st[idx]  = lpht_pkg::ST_LIVE;
        mirror_key[idx] = key;
        mirror_val[idx] = value;
        where = idx;
        return lpht_pkg::RES_OK;
      end
      idx = (idx + 1) % SLOTS;
    end
    return lpht_pkg::RES_FULL;
  endfunction

  // Apply one command to the mirror and return the reply it must produce
  function automatic reply_t apply_op(input lpht_pkg::cmd_t cmd, input logic [KB-1:0] key,
                                      input logic [VB-1:0] value);
    reply_t r;
    int where;
    r.status = lpht_pkg::RES_NOTFOUND;
    r.value  = '0;
    r.slot   = '0;
    where    = 0;
    case (cmd)
      lpht_pkg::CMD_INSERT: begin
        r.status = place_entry(key, value, where);
        if (r.status == lpht_pkg::RES_OK) r.value = value;
      end
      lpht_pkg::CMD_FIND: begin
        if (locate_entry(key, where)) begin
          r.status = lpht_pkg::RES_OK;
          r.value  = mirror_val[where];
        end
      end
      lpht_pkg::CMD_ERASE: begin
        if (locate_entry(key, where)) begin
          r.status = lpht_pkg::RES_OK;
          r.value  = mirror_val[where];
          mirror_st[where] = lpht_pkg::ST_TOMB;
        end
      end
      default: begin
        if (locate_entry(key, where)) begin
          r.status = lpht_pkg::RES_OK;
          r.value  = mirror_val[where];
        end else begin
          r.status = place_entry(key, '0, where);
        end
      end
    endcase
    if (r.status == lpht_pkg::RES_OK) begin
      r.slot = lpht_pkg::OUT_SLOT_BITS'(where);
    end else begin
      r.value = '0;
    end
    return r;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (mirror_st[i] == lpht_pkg::ST_LIVE) n++;
    return n;
  endfunction

  // Return a key that is live in the mirror, starting the scan at random
  function automatic bit live_key(output logic [KB-1:0] key);
    int idx;
    idx = $urandom_range(0, SLOTS - 1);
    key = '0;
    for (int n = 0; n < SLOTS; n++) begin
      if (mirror_st[idx] == lpht_pkg::ST_LIVE) begin
        key = mirror_key[idx];
        return 1'b1;
      end
      idx = (idx + 1) % SLOTS;
    end
    return 1'b0;
  endfunction

  // Mostly keys that hit or that crowd a few home slots; some fully random
  function automatic logic [KB-1:0] choose_key();
    int r;
    logic [KB-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 45 && live_key(k)) return k;
    if (r < 85)
      return {key_hi[$urandom_range(0, 3)],
              lpht_pkg::SLOT_BITS'(cluster_base + int'($urandom_range(0, 5)))};
    return $urandom;
  endfunction

  function automatic lpht_pkg::cmd_t choose_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return lpht_pkg::CMD_INSERT;
    if (r < 60) return lpht_pkg::CMD_FIND;
    if (r < 85) return lpht_pkg::CMD_ERASE;
    return lpht_pkg::CMD_LOOKUP_ADD;
  endfunction

  function automatic void add_row(input lpht_pkg::cmd_t cmd, input logic [KB-1:0] key,
                                  input logic [VB-1:0] value, input bit typed,
                                  input lpht_pkg::status_t st, input logic [VB-1:0] val,
                                  input int slot);
    dir_row_t row;
    row.cmd         = cmd;
    row.key         = key;
    row.value       = value;
    row.typed       = typed;
    row.want.status = st;
    row.want.value  = val;
    row.want.slot   = lpht_pkg::OUT_SLOT_BITS'(slot);
    dir_tab = {dir_tab, row};
  endfunction

  // -------------------------------------------------------------------------
  // Input side: one transaction per call, entered and left at a falling edge
  // -------------------------------------------------------------------------
  task automatic send_op(input lpht_pkg::cmd_t cmd, input logic [KB-1:0] key,
                         input logic [VB-1:0] value,
                         input bit typed, input reply_t want);
    reply_t r;
    r = apply_op(cmd, key, value);
    if (typed) r = want;
    reply_q = {reply_q, r};
    // Drop valid for a random burst now and then
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {value, key};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold the input quiet until every owed reply has come back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (reply_q.size() != 0);
  endtask

  task automatic run_mixed(input int count, input int hold_at, input int pause_at);
    reply_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain_replies();
      send_op(choose_cmd(), choose_key(), $urandom, 1'b0, none);
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    reply_t none;
    logic [KB-1:0] k;
    none = '0;
    errors     = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = lpht_pkg::CMD_INSERT;
    for (int i = 0; i < SLOTS; i++) begin
      mirror_st[i]  = lpht_pkg::ST_EMPTY;
      mirror_key[i] = '0;
      mirror_val[i] = '0;
    end
    key_hi[0] = '0;
    key_hi[1] = '1;
    key_hi[2] = HI_BITS'($urandom);
    key_hi[3] = HI_BITS'($urandom);
    cluster_base = $urandom_range(0, SLOTS - 1);

    // Empty-table misses, extremes, duplicate, collisions, erase to a
    // tombstone, a find that pulls its entry back, lookup-or-add hit and add,
    // tombstone reuse, and a probe that wraps past the last slot
    add_row(lpht_pkg::CMD_FIND,       32'h0000_0000, 32'h0000_0000, 1'b1,
            lpht_pkg::RES_NOTFOUND, 32'h0, 0);
    add_row(lpht_pkg::CMD_ERASE,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            lpht_pkg::RES_NOTFOUND, 32'h0, 0);
    add_row(lpht_pkg::CMD_INSERT,     32'h0000_0000, 32'h0000_0000, 1'b1,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_INSERT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            lpht_pkg::RES_OK, 32'hFFFF_FFFF, 63);
    add_row(lpht_pkg::CMD_INSERT,     32'h0000_0000, 32'h0000_1234, 1'b1,
            lpht_pkg::RES_DUP, 32'h0, 0);
    add_row(lpht_pkg::CMD_INSERT,     32'h0000_0040, 32'h5A5A_5A5A, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_INSERT,     32'h0000_0080, 32'hA5A5_A5A5, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_ERASE,      32'h0000_0000, 32'h0000_0000, 1'b1,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_FIND,       32'h0000_0080, 32'h0000_0000, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_FIND,       32'h0000_0080, 32'hFFFF_FFFF, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_LOOKUP_ADD, 32'h0000_0040, 32'h1111_1111, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_LOOKUP_ADD, 32'hAAAA_AAAA, 32'h2222_2222, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_LOOKUP_ADD, 32'h0000_00C0, 32'h3333_3333, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_ERASE,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
            lpht_pkg::RES_OK, 32'hFFFF_FFFF, 63);
    add_row(lpht_pkg::CMD_INSERT,     32'h0000_003F, 32'h0F0F_0F0F, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_INSERT,     32'h0000_007F, 32'h8000_0000, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_FIND,       32'h0000_007F, 32'h0000_0000, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_ERASE,      32'h0000_007F, 32'h0000_0000, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_FIND,       32'h0000_007F, 32'h0000_0000, 1'b1,
            lpht_pkg::RES_NOTFOUND, 32'h0, 0);
    add_row(lpht_pkg::CMD_LOOKUP_ADD, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_INSERT,     32'h1234_5678, 32'hFFFF_FFFF, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_ERASE,      32'hAAAA_AAAA, 32'h0000_0000, 1'b0,
            lpht_pkg::RES_OK, 32'h0, 0);
    add_row(lpht_pkg::CMD_FIND,       32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
            lpht_pkg::RES_NOTFOUND, 32'h0, 0);

    repeat (RESET_LEN) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_op(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].value, dir_tab[i].typed,
              dir_tab[i].want);

    // Clustered traffic; stall the receiver long enough to back up the input,
    // later pause the sender until the block has caught up
    run_mixed(250, 100, 200);

    // Fill every slot, then hit the full table from all sides: inserts and
    // adds that cannot land, misses that wrap all the way round, and hits
    while (live_count() < SLOTS)
      send_op(lpht_pkg::CMD_INSERT, $urandom, $urandom, 1'b0, none);
    repeat (30) begin
      case ($urandom_range(0, 3))
        0: send_op(lpht_pkg::CMD_INSERT, $urandom, $urandom, 1'b0, none);
        1: send_op(lpht_pkg::CMD_LOOKUP_ADD, $urandom, $urandom, 1'b0, none);
        2: send_op(lpht_pkg::CMD_FIND, $urandom, $urandom, 1'b0, none);
        default: begin
          void'(live_key(k));
          send_op(lpht_pkg::CMD_FIND, k, $urandom, 1'b0, none);
        end
      endcase
    end

    // Erase most entries so probes run through long tombstone chains
    while (live_count() > 8) begin
      void'(live_key(k));
      send_op(lpht_pkg::CMD_ERASE, k, $urandom, 1'b0, none);
    end

    cluster_base = $urandom_range(0, SLOTS - 1);
    run_mixed(200, -1, -1);

    // Last stretch: both sides flat out
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    cluster_base = $urandom_range(0, SLOTS - 1);
    run_mixed(250, -1, -1);

    drain_replies();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Output side: random ready bursts, plus one long hold on request
  // -------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Reply checker: compare each accepted transaction with the oldest entry
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply: expected none, actual status=%0d value=%h slot=%0d",
                 $time, out_tuser, out_tdata[31:0], out_tdata[37:32]);
      end else begin
        want = reply_q.pop_front();
        if (out_tuser !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_tuser);
        end
        if (out_tdata[31:0] !== want.value) begin
          errors++;
          $display("%0t: found_value mismatch: expected %h, actual %h",
                   $time, want.value, out_tdata[31:0]);
        end
        if (out_tdata[37:32] !== want.slot) begin
          errors++;
          $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                   $time, want.slot, out_tdata[37:32]);
        end
        if (out_tdata[39:38] !== 2'b00) begin
          errors++;
          $display("%0t: tdata padding mismatch: expected 0, actual %b",
                   $time, out_tdata[39:38]);
        end
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule

/* linear_probe_hash_table.f */
rtl/lpht_pkg.sv
rtl/lpht_front.sv
rtl/lpht_queue.sv
rtl/lpht_back.sv
rtl/linear_probe_hash_table.sv
test/linear_probe_hash_table_test.sv
